/* rtl/core/bounded_service_queue_monitor_top_macros.svh */
// Assertion macros shared by the queue monitor RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef BOUNDED_SERVICE_QUEUE_MONITOR_TOP_MACROS_SVH
`define BOUNDED_SERVICE_QUEUE_MONITOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define BSQM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition on the cycle after the trigger
`define BSQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSQM_ASSERT(lbl, prop, msg)
`define BSQM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/bsqm_pkg.sv */
// Shared constants and controller command type for the queue monitor.
// No dependencies; imported by the top level, controller and datapath, and referenced by the interfaces.
`default_nettype none

package bsqm_pkg;

  // queue store geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TAIL_W      = OCC_W + 1;

  // field widths
  localparam int CAP_W = 7;
  localparam int SVC_W = 2;
  localparam int CNT_W = 32;
  localparam int SUM_W = 48;
  localparam int LEN_W = 7;
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_IDX_CAPACITY = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input word
    logic push;     // admit or reject the arrival
    logic read;     // fetch head entry
    logic pop;      // serve, count down, accumulate, advance tick
    logic load;     // copy state into the output register
  } bsqm_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/bsqm_ifs.sv */
// Handshake channel interfaces for the queue monitor input and result words.
// Depends on bsqm_pkg for field widths.
`default_nettype none

interface bsqm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         arrival;
  logic [bsqm_pkg::SVC_W-1:0]   service_time;

  modport source (output valid, output arrival, output service_time, input ready);
  modport sink   (input valid, input arrival, input service_time, output ready);
endinterface

interface bsqm_out_if;
  logic                         valid;
  logic                         ready;
  logic [bsqm_pkg::CNT_W-1:0]   arrived_count;
  logic [bsqm_pkg::CNT_W-1:0]   served_count;
  logic [bsqm_pkg::CNT_W-1:0]   turned_away_count;
  logic [bsqm_pkg::SUM_W-1:0]   length_sum;
  logic [bsqm_pkg::SUM_W-1:0]   wait_sum;
  logic [bsqm_pkg::LEN_W-1:0]   queue_length;
  logic [bsqm_pkg::SVC_W-1:0]   service_left;

  modport source (output valid, output arrived_count, output served_count,
                  output turned_away_count, output length_sum, output wait_sum,
                  output queue_length, output service_left, input ready);
  modport sink   (input valid, input arrived_count, input served_count,
                  input turned_away_count, input length_sum, input wait_sum,
                  input queue_length, input service_left, output ready);
endinterface

`default_nettype wire

/* rtl/core/bounded_service_queue_monitor_top.sv */
// Top level of the bounded single-server queue monitor: APB capacity
// register plus controller and datapath. Depends on bsqm_pkg, bsqm_ifs.
`default_nettype none

// Each input word is one tick of a single-server queue: an arrival (with its
// service time) is admitted into a circular store of QUEUE_DEPTH entries or
// turned away when the queue holds queue_capacity customers; an idle server
// then takes the head, and one result word with saturating counts, sums,
// queue length and remaining service is produced per tick. A tick steps
// through accept, push, head read from the single-port store, serve and
// output load, and the next word is accepted only after that load; a stalled
// result holds the sequencer in its load step. The store needs no clearing
// pass after reset. Write queue_capacity at address 0 only
// while no tick is in flight.
module bounded_service_queue_monitor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  bsqm_in_if.sink                       in_chan,
  bsqm_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsqm_pkg::APB_AW-1:0]   paddr,
  input  logic [bsqm_pkg::APB_DW-1:0]   pwdata,
  output logic [bsqm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import bsqm_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             cap_sel;
  bsqm_cmd_t        cmd;

  // capacity register
  assign cap_sel = (paddr[APB_AW-1] == REG_IDX_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && cap_sel) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = cap_sel ? APB_DW'(cap_r) : '0;

  bsqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  bsqm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .queue_capacity    (cap_r),
    .arrival           (in_chan.arrival),
    .service_time      (in_chan.service_time),
    .arrived_count     (out_chan.arrived_count),
    .served_count      (out_chan.served_count),
    .turned_away_count (out_chan.turned_away_count),
    .length_sum        (out_chan.length_sum),
    .wait_sum          (out_chan.wait_sum),
    .queue_length      (out_chan.queue_length),
    .service_left      (out_chan.service_left)
  );

endmodule

`default_nettype wire

/* rtl/core/bsqm_ctrl.sv */
// Sequencing state machine of the queue monitor: steps one word through
// push, head read, pop and output load. Depends on bsqm_pkg and the macros.
`default_nettype none
`include "bounded_service_queue_monitor_top_macros.svh"

module bsqm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output bsqm_pkg::bsqm_cmd_t cmd
);
  import bsqm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PUSH, S_READ, S_POP, S_OUT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // output register is free now or drains this cycle
  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `BSQM_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
  `BSQM_ASSERT_NEXT(a_accept_push, in_valid && in_ready, cmd.push, "accepted word not pushed next cycle")

endmodule

`default_nettype wire

/* rtl/core/bsqm_datapath.sv */
// Queue store, occupancy and pointer logic, saturating counters and the
// result register of the queue monitor. Depends on bsqm_pkg and the macros.
`default_nettype none
`include "bounded_service_queue_monitor_top_macros.svh"

module bsqm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsqm_pkg::bsqm_cmd_t          cmd,
  input  logic [bsqm_pkg::CAP_W-1:0]   queue_capacity,
  input  logic                         arrival,
  input  logic [bsqm_pkg::SVC_W-1:0]   service_time,
  output logic [bsqm_pkg::CNT_W-1:0]   arrived_count,
  output logic [bsqm_pkg::CNT_W-1:0]   served_count,
  output logic [bsqm_pkg::CNT_W-1:0]   turned_away_count,
  output logic [bsqm_pkg::SUM_W-1:0]   length_sum,
  output logic [bsqm_pkg::SUM_W-1:0]   wait_sum,
  output logic [bsqm_pkg::LEN_W-1:0]   queue_length,
  output logic [bsqm_pkg::SVC_W-1:0]   service_left
);
  import bsqm_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] stamp;
    logic [SVC_W-1:0] dur;
  } entry_t;

  // store, no reset: a head entry read from it is used only while the queue holds entries
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_r;

  // latched input word
  logic             arr_r;
  logic [SVC_W-1:0] svc_r;

  // queue and statistics state
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [SVC_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] adm_r, adm_nxt;
  logic [CNT_W-1:0] srv_r, srv_nxt;
  logic [CNT_W-1:0] rej_r, rej_nxt;
  logic [SUM_W-1:0] len_r, len_nxt;
  logic [SUM_W-1:0] wait_r, wait_nxt;

  // result register
  logic [CNT_W-1:0] o_adm_r, o_srv_r, o_rej_r;
  logic [SUM_W-1:0] o_len_r, o_wait_r;
  logic [LEN_W-1:0] o_qlen_r;
  logic [SVC_W-1:0] o_left_r;

  logic [CMP_W-1:0]  cap_eff;
  logic              admit;
  logic [TAIL_W-1:0] tail_sum, tail_mod;
  logic [PTR_W-1:0]  tail;
  logic              pop_go;
  logic [CNT_W-1:0]  waited;
  logic [SVC_W-1:0]  cnt_sel;
  logic [OCC_W-1:0]  occ_pop;
  logic [SUM_W:0]    wait_add, len_add;

  // admission: capacity clipped to store depth
  always_comb begin
    if (CMP_W'(queue_capacity) > CMP_W'(QUEUE_DEPTH)) begin
      cap_eff = CMP_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = CMP_W'(queue_capacity);
    end
    admit = arr_r && (CMP_W'(occ_r) < cap_eff);
  end

  // tail = (head + occupancy) mod depth, sum stays below twice the depth
  always_comb begin
    tail_sum = TAIL_W'(head_r) + TAIL_W'(occ_r);
    if (tail_sum >= TAIL_W'(QUEUE_DEPTH)) begin
      tail_mod = tail_sum - TAIL_W'(QUEUE_DEPTH);
    end else begin
      tail_mod = tail_sum;
    end
    tail = tail_mod[PTR_W-1:0];
  end

  // serve step terms
  always_comb begin
    pop_go   = (cnt_r == '0) && (occ_r != '0);
    waited   = tick_r - rd_r.stamp;
    cnt_sel  = pop_go ? rd_r.dur : cnt_r;
    occ_pop  = occ_r - OCC_W'(pop_go);
    wait_add = {1'b0, wait_r} + (SUM_W+1)'(waited);
    len_add  = {1'b0, len_r} + (SUM_W+1)'(occ_pop);
  end

  // next state
  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    tick_nxt = tick_r;
    cnt_nxt  = cnt_r;
    adm_nxt  = adm_r;
    srv_nxt  = srv_r;
    rej_nxt  = rej_r;
    len_nxt  = len_r;
    wait_nxt = wait_r;
    if (cmd.push && arr_r) begin
      if (admit) begin
        occ_nxt = occ_r + OCC_W'(1);
        adm_nxt = (&adm_r) ? adm_r : adm_r + CNT_W'(1);
      end else begin
        rej_nxt = (&rej_r) ? rej_r : rej_r + CNT_W'(1);
      end
    end
    if (cmd.pop) begin
      if (pop_go) begin
        head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
        srv_nxt  = (&srv_r) ? srv_r : srv_r + CNT_W'(1);
        wait_nxt = wait_add[SUM_W] ? '1 : wait_add[SUM_W-1:0];
      end
      occ_nxt  = occ_pop;
      cnt_nxt  = (cnt_sel != '0) ? cnt_sel - SVC_W'(1) : '0;
      len_nxt  = len_add[SUM_W] ? '1 : len_add[SUM_W-1:0];
      tick_nxt = tick_r + CNT_W'(1);
    end
  end

  // store write and registered head read
  always_ff @(posedge clk) begin
    if (cmd.push && admit) begin
      mem[tail] <= '{stamp: tick_r, dur: svc_r};
    end
    if (cmd.read) begin
      rd_r <= mem[head_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arr_r <= arrival;
      svc_r <= service_time;
    end
    if (cmd.load) begin
      o_adm_r  <= adm_r;
      o_srv_r  <= srv_r;
      o_rej_r  <= rej_r;
      o_len_r  <= len_r;
      o_wait_r <= wait_r;
      o_qlen_r <= LEN_W'(occ_r);
      o_left_r <= cnt_r;
    end
  end

  // queue state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
      tick_r <= '0;
      cnt_r  <= '0;
      adm_r  <= '0;
      srv_r  <= '0;
      rej_r  <= '0;
      len_r  <= '0;
      wait_r <= '0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
      tick_r <= tick_nxt;
      cnt_r  <= cnt_nxt;
      adm_r  <= adm_nxt;
      srv_r  <= srv_nxt;
      rej_r  <= rej_nxt;
      len_r  <= len_nxt;
      wait_r <= wait_nxt;
    end
  end

  assign arrived_count     = o_adm_r;
  assign served_count      = o_srv_r;
  assign turned_away_count = o_rej_r;
  assign length_sum        = o_len_r;
  assign wait_sum          = o_wait_r;
  assign queue_length      = o_qlen_r;
  assign service_left      = o_left_r;

  `BSQM_ASSERT(a_occ_bound, occ_r <= OCC_W'(QUEUE_DEPTH), "occupancy above store depth")
  `BSQM_ASSERT_NEXT(a_push_occ, cmd.push && admit, occ_r == $past(occ_r) + OCC_W'(1), "admitted word did not raise occupancy")
  `BSQM_ASSERT_NEXT(a_pop_tick, cmd.pop, tick_r == $past(tick_r) + CNT_W'(1), "tick did not advance after serve step")

endmodule

`default_nettype wire
